// File: rtl/eop_pkg.sv
`default_nettype none

package eop_pkg;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_ZEBRA = 2'd1,
        MODE_JET   = 2'd2
    } mode_t;

    localparam logic [1:0] MODE_RESET    = MODE_NONE;
    localparam logic [5:0] PERCENT_RESET = 6'd2;

    // Luma weights and the reciprocal of 1000 scaled by 2^28. The reciprocal
    // is rounded up, and the error stays below 1/1000 over the full sum range.
    localparam logic [17:0] LUMA_WR     = 18'd299;
    localparam logic [17:0] LUMA_WG     = 18'd587;
    localparam logic [17:0] LUMA_WB     = 18'd114;
    localparam logic [35:0] LUMA_RECIP  = 36'd268436;
    localparam int          LUMA_SHIFT  = 28;
    localparam logic [17:0] LUMA_SCALE  = 18'd1000;
    localparam logic [17:0] LUMA_SUM_MAX = 18'd255000;

    // Reciprocal of 100 scaled by 2^19 for the zebra threshold.
    localparam logic [26:0] PCT_RECIP = 27'd5243;
    localparam int          PCT_SHIFT = 19;

    localparam logic [9:0] JET_K_RED   = 10'd765;
    localparam logic [9:0] JET_K_GREEN = 10'd510;
    localparam logic [9:0] JET_K_BLUE  = 10'd255;
    localparam logic [9:0] JET_D_ZERO  = 10'd382;
    localparam logic [9:0] JET_D_FULL  = 10'd127;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       stripe;
        logic [7:0] luma;
    } pix_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] lo;
    } cfg_t;

    function automatic logic [7:0] zebra_low(input logic [5:0] pct);
        logic [26:0] scaled;
        logic [26:0] prod;
        begin
            scaled = 27'(pct) * 27'd255;
            prod   = scaled * PCT_RECIP;
            return prod[PCT_SHIFT +: 8];
        end
    endfunction

    function automatic logic [7:0] jet_channel(input logic [7:0] luma, input logic [9:0] k);
        logic [9:0] l4;
        logic [9:0] d;
        logic [9:0] v;
        begin
            l4 = {luma, 2'b00};
            d  = (l4 >= k) ? (l4 - k) : (k - l4);
            v  = JET_D_ZERO - d;
            if (d > JET_D_ZERO)
            begin
                return 8'd0;
            end
            else if (d <= JET_D_FULL)
            begin
                return 8'hFF;
            end
            else
            begin
                return v[7:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/exposure_overlay_pixel_top.sv
`default_nettype none

// Channel   Handshake             Payload
// input     in_valid / in_stall   red_in, green_in, blue_in, column, line_index
// output    out_valid / out_stall red_out, green_out, blue_out
// config    APB write/read        overlay_mode at 0x0, zebra_percent at 0x4
//
// One item is accepted per cycle while in_stall is low.
// The stages are the input register, the weighted sum, the luma divide and the result.
// Reset clears all stage valid flags and loads the register reset values.
// A stall on the output holds the result and fills the empty stages behind it.
// Input stall rises only when every stage holds an item.
module exposure_overlay_pixel_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [9:0]  column,
    input  wire logic [9:0]  line_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       red_out,
    output logic [7:0]       green_out,
    output logic [7:0]       blue_out
);
    import eop_pkg::*;

    cfg_t cfg;
    pix_t pix;
    logic pix_valid;
    logic pix_stall;

    eop_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    eop_luma u_luma (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .column     (column),
        .line_index (line_index),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix        (pix)
    );

    eop_overlay u_overlay (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

endmodule

`default_nettype wire

// File: rtl/eop_cfg.sv
`default_nettype none

module eop_cfg (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    output eop_pkg::cfg_t     cfg
);
    import eop_pkg::*;

    localparam logic REG_MODE    = 1'b0;
    localparam logic REG_PERCENT = 1'b1;

    logic [1:0] mode_reg;
    logic [5:0] pct_reg;
    logic [7:0] lo_reg;
    logic       wr_en;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_RESET;
            pct_reg  <= PERCENT_RESET;
            lo_reg   <= zebra_low(PERCENT_RESET);
        end
        else
        begin
            if (wr_en)
            begin
                unique case (reg_sel)
                    REG_MODE:    mode_reg <= pwdata[1:0];
                    REG_PERCENT: pct_reg  <= pwdata[5:0];
                    default:     ;
                endcase
            end
            lo_reg <= zebra_low(pct_reg);
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MODE:    prdata = {30'd0, mode_reg};
            REG_PERCENT: prdata = {26'd0, pct_reg};
            default:     prdata = 32'd0;
        endcase
    end

    assign cfg.mode = mode_reg;
    assign cfg.lo   = lo_reg;

    a_lo_floor: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((14'(lo_reg) * 14'd100 <= 14'($past(pct_reg)) * 14'd255) &&
                  (14'($past(pct_reg)) * 14'd255 < 14'(lo_reg) * 14'd100 + 14'd100)))
        else $error("Zebra threshold does not match the percent register.");

endmodule

`default_nettype wire

// File: rtl/eop_luma.sv
`default_nettype none

module eop_luma (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [9:0]  column,
    input  wire logic [9:0]  line_index,
    output logic             pix_valid,
    input  wire logic        pix_stall,
    output eop_pkg::pix_t    pix
);
    import eop_pkg::*;

    logic        v1_reg;
    logic        v2_reg;
    logic        v3_reg;
    logic        ld1;
    logic        ld2;
    logic        ld3;

    logic [7:0]  r1_reg;
    logic [7:0]  g1_reg;
    logic [7:0]  b1_reg;
    logic [2:0]  col1_reg;
    logic [2:0]  row1_reg;

    logic [7:0]  r2_reg;
    logic [7:0]  g2_reg;
    logic [7:0]  b2_reg;
    logic        stripe2_reg;
    logic [17:0] sum_reg;

    pix_t        pix_reg;

    logic [2:0]  diag;
    logic        stripe_next;
    logic [17:0] sum_next;
    logic [35:0] prod;
    logic [7:0]  luma_next;

    assign ld3 = !v3_reg || !pix_stall;
    assign ld2 = !v2_reg || ld3;
    assign ld1 = !v1_reg || ld2;
    assign in_stall = !ld1;

    assign diag        = col1_reg + row1_reg;
    assign stripe_next = !diag[2];
    assign sum_next    = LUMA_WR * 18'(r1_reg) + LUMA_WG * 18'(g1_reg) + LUMA_WB * 18'(b1_reg);
    assign prod        = 36'(sum_reg) * LUMA_RECIP;
    assign luma_next   = prod[LUMA_SHIFT +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= in_valid;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            r1_reg   <= red_in;
            g1_reg   <= green_in;
            b1_reg   <= blue_in;
            col1_reg <= column[2:0];
            row1_reg <= line_index[2:0];
        end
        if (ld2 && v1_reg)
        begin
            r2_reg      <= r1_reg;
            g2_reg      <= g1_reg;
            b2_reg      <= b1_reg;
            stripe2_reg <= stripe_next;
            sum_reg     <= sum_next;
        end
        if (ld3 && v2_reg)
        begin
            pix_reg.red    <= r2_reg;
            pix_reg.green  <= g2_reg;
            pix_reg.blue   <= b2_reg;
            pix_reg.stripe <= stripe2_reg;
            pix_reg.luma   <= luma_next;
        end
    end

    assign pix_valid = v3_reg;
    assign pix       = pix_reg;

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (sum_reg <= LUMA_SUM_MAX))
        else $error("Weighted pixel sum is out of range.");

    a_luma_floor: assert property (@(posedge clk) disable iff (!rst_n)
        (ld3 && v2_reg) |=>
            ((18'(pix_reg.luma) * LUMA_SCALE <= $past(sum_reg)) &&
             ($past(sum_reg) < 18'(pix_reg.luma) * LUMA_SCALE + LUMA_SCALE)))
        else $error("Luma is not the floor of the weighted sum.");

endmodule

`default_nettype wire

// File: rtl/eop_overlay.sv
`default_nettype none

module eop_overlay (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire eop_pkg::cfg_t cfg,
    input  wire logic         pix_valid,
    output logic              pix_stall,
    input  wire eop_pkg::pix_t pix,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out
);
    import eop_pkg::*;

    logic       valid_reg;
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;
    logic       ld;

    logic [7:0] hi;
    logic       is_high;
    logic       is_low;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    assign ld        = !valid_reg || !out_stall;
    assign pix_stall = !ld;

    assign hi      = 8'hFF - cfg.lo;
    assign is_high = pix.luma >= hi;
    assign is_low  = pix.luma <= cfg.lo;

    always_comb
    begin
        red_next   = pix.red;
        green_next = pix.green;
        blue_next  = pix.blue;
        case (cfg.mode)
            MODE_ZEBRA:
            begin
                if ((is_high || is_low) && pix.stripe)
                begin
                    red_next   = is_high ? 8'h00 : 8'hFF;
                    green_next = is_high ? 8'h00 : 8'hFF;
                    blue_next  = is_high ? 8'h00 : 8'hFF;
                end
            end
            MODE_JET:
            begin
                red_next   = jet_channel(pix.luma, JET_K_RED);
                green_next = jet_channel(pix.luma, JET_K_GREEN);
                blue_next  = jet_channel(pix.luma, JET_K_BLUE);
            end
            default:
            begin
                red_next   = pix.red;
                green_next = pix.green;
                blue_next  = pix.blue;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ld)
        begin
            valid_reg <= pix_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld && pix_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

    a_zebra_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ld && pix_valid && (cfg.mode == MODE_ZEBRA)) |=>
            ((red_reg == $past(pix.red) && green_reg == $past(pix.green) &&
              blue_reg == $past(pix.blue)) ||
             (red_reg == 8'h00 && green_reg == 8'h00 && blue_reg == 8'h00) ||
             (red_reg == 8'hFF && green_reg == 8'hFF && blue_reg == 8'hFF)))
        else $error("Zebra result is neither the source pixel nor black or white.");

endmodule

`default_nettype wire

// File: sim/exposure_overlay_pixel_top_test.sv
`timescale 1ns / 100ps

module exposure_overlay_pixel_top_test;

    import eop_pkg::*;

    localparam logic [2:0]  ADDR_MODE    = 3'd0;
    localparam logic [2:0]  ADDR_PERCENT = 3'd4;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int          SETTLE_CYCLES = 10;
    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          RANDOM_PHASES = 10;
    localparam int          PHASE_PIXELS  = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] column;
        logic [9:0] line_index;
    } pixel_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } shade_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  red_in = '0;
    logic [7:0]  green_in = '0;
    logic [7:0]  blue_in = '0;
    logic [9:0]  column = '0;
    logic [9:0]  line_index = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;

    logic [1:0]  cfg_mode = MODE_RESET;
    logic [5:0]  cfg_percent = PERCENT_RESET;

    pixel_t      pending_pixels[$];
    shade_t      expected_shades[$];
    pixel_t      next_pixel;
    shade_t      want;

    int          burst_left = 0;
    int          gap_left = 0;
    bit          drain_pause = 1'b0;
    int          stall_run = 0;
    int          stall_pct = 0;
    int          cycle_count = 0;
    int          mismatches = 0;
    int          checked_pixels = 0;
    int          settings_count = 0;
    int          mode_phases[4] = '{0, 0, 0, 0};

    exposure_overlay_pixel_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .column     (column),
        .line_index (line_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] jet_level(input logic [7:0] luma, input int k);
        int delta;
        int level;
        begin
            delta = 4 * int'(luma) - k;
            if (delta < 0)
            begin
                delta = -delta;
            end
            level = 765 - 2 * delta;
            if (level < 0)
            begin
                return 8'd0;
            end
            level = level / 2;
            if (level > 255)
            begin
                level = 255;
            end
            return level[7:0];
        end
    endfunction

    function automatic shade_t predict_overlay(input pixel_t p);
        int         weighted;
        logic [7:0] luma;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [2:0] diagonal;
        bit         bright;
        bit         dark;
        shade_t     s;
        begin
            weighted = 299 * int'(p.red) + 587 * int'(p.green) + 114 * int'(p.blue);
            luma = 8'(weighted / 1000);
            s.red = p.red;
            s.green = p.green;
            s.blue = p.blue;
            case (cfg_mode)
                MODE_ZEBRA:
                begin
                    lo = 8'((int'(cfg_percent) * 255) / 100);
                    hi = 8'd255 - lo;
                    bright = luma >= hi;
                    dark = luma <= lo;
                    diagonal = p.column[2:0] + p.line_index[2:0];
                    if ((bright || dark) && !diagonal[2])
                    begin
                        s.red = bright ? 8'd0 : 8'd255;
                        s.green = s.red;
                        s.blue = s.red;
                    end
                end
                MODE_JET:
                begin
                    s.red = jet_level(luma, int'(JET_K_RED));
                    s.green = jet_level(luma, int'(JET_K_GREEN));
                    s.blue = jet_level(luma, int'(JET_K_BLUE));
                end
                default:
                begin
                end
            endcase
            return s;
        end
    endfunction

    function automatic pixel_t make_pixel(input int r, input int g, input int b,
                                          input int col, input int row);
        pixel_t p;
        begin
            p.red = 8'(r);
            p.green = 8'(g);
            p.blue = 8'(b);
            p.column = 10'(col);
            p.line_index = 10'(row);
            return p;
        end
    endfunction

    function automatic pixel_t random_pixel();
        int base;
        pixel_t p;
        begin
            p = make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1023),
                           $urandom_range(0, 1023));
            // Near-gray pixels close to the clipping bands exercise the zebra limits.
            if ($urandom_range(0, 2) == 0)
            begin
                base = $urandom_range(0, 1) ? $urandom_range(0, 110) : $urandom_range(140, 255);
                p.red = 8'(base) ^ 8'($urandom_range(0, 3));
                p.green = 8'(base) ^ 8'($urandom_range(0, 3));
                p.blue = 8'(base) ^ 8'($urandom_range(0, 3));
            end
            return p;
        end
    endfunction

    task automatic wait_idle();
        begin
            while (pending_pixels.size() != 0 || in_valid || expected_shades.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        begin
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= addr;
            pwdata <= value;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            if (addr == ADDR_MODE)
            begin
                cfg_mode = value[1:0];
            end
            else
            begin
                cfg_percent = value[5:0];
            end
        end
    endtask

    task automatic apply_setting(input logic [1:0] mode, input logic [5:0] pct);
        begin
            wait_idle();
            write_register(ADDR_MODE, 32'(mode));
            write_register(ADDR_PERCENT, 32'(pct));
            settings_count++;
            mode_phases[mode]++;
        end
    endtask

    task automatic queue_gray(input int level, input int col, input int row);
        begin
            pending_pixels.push_back(make_pixel(level, level, level, col, row));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (drain_pause)
            begin
                if (!in_valid && expected_shades.size() == 0)
                begin
                    drain_pause = 1'b0;
                end
                in_valid <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_pixels.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                next_pixel = pending_pixels.pop_front();
                red_in <= next_pixel.red;
                green_in <= next_pixel.green;
                blue_in <= next_pixel.blue;
                column <= next_pixel.column;
                line_index <= next_pixel.line_index;
                in_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                            : $urandom_range(1, 8);
                    gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
                    drain_pause = ($urandom_range(0, 15) == 0);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_run = $urandom_range(5, 50);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 90;
                endcase
            end
            stall_run--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_shades.push_back(predict_overlay(make_pixel(red_in, green_in,
                                                          blue_in, column, line_index)));
            end
            if (out_valid && !out_stall)
            begin
                checked_pixels++;
                if (expected_shades.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Unexpected pixel %0d/%0d/%0d with no item pending",
                                 red_out, green_out, blue_out);
                    end
                end
                else
                begin
                    want = expected_shades.pop_front();
                    if (red_out !== want.red || green_out !== want.green
                        || blue_out !== want.blue)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("Pixel mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.red, want.green, want.blue,
                                     red_out, green_out, blue_out);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("exposure_overlay_pixel_top_test failed");
            $finish;
        end
    end

    initial
    begin
        logic [1:0] mode;
        logic [5:0] pct;
        logic [5:0] pct_edges[8];
        pct_edges = '{6'd0, 6'd1, 6'd2, 6'd40, 6'd41, 6'd50, 6'd51, 6'd63};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // The reset settings pass pixels through.
        pending_pixels.push_back(make_pixel(0, 0, 0, 0, 0));
        pending_pixels.push_back(make_pixel(255, 255, 255, 1023, 1023));

        // A zero percent leaves only full white and full black in the bands.
        apply_setting(MODE_ZEBRA, 6'd0);
        queue_gray(255, 0, 0);
        queue_gray(0, 0, 0);
        queue_gray(128, 4, 0);

        apply_setting(MODE_ZEBRA, 6'd40);
        queue_gray(153, 1, 2);
        queue_gray(102, 0, 0);
        queue_gray(200, 2, 2);
        queue_gray(10, 1023, 1);

        // Above fifty percent the bands overlap and every pixel on a stripe is clipped.
        apply_setting(MODE_ZEBRA, 6'd63);
        queue_gray(128, 3, 0);
        pending_pixels.push_back(make_pixel(255, 0, 0, 5, 7));

        apply_setting(MODE_JET, 6'd2);
        queue_gray(0, 0, 0);
        queue_gray(32, 1, 1);
        queue_gray(95, 2, 2);
        queue_gray(128, 3, 3);
        queue_gray(160, 4, 4);
        queue_gray(255, 5, 5);

        // The unused mode code behaves like no overlay.
        apply_setting(MODE_UNUSED, 6'd20);
        pending_pixels.push_back(make_pixel(17, 200, 99, 8, 9));
        queue_gray(255, 0, 0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 7))
                0: mode = MODE_NONE;
                1: mode = MODE_UNUSED;
                2, 3, 4: mode = MODE_ZEBRA;
                default: mode = MODE_JET;
            endcase
            pct = $urandom_range(0, 1) ? pct_edges[$urandom_range(0, 7)]
                                       : 6'($urandom_range(0, 63));
            apply_setting(mode, pct);
            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                pending_pixels.push_back(random_pixel());
            end
        end

        wait_idle();
        $display("Checked %0d overlaid pixels over %0d register settings.",
                 checked_pixels, settings_count);
        $display("Phases per mode none/zebra/jet/unused: %0d/%0d/%0d/%0d.",
                 mode_phases[0], mode_phases[1], mode_phases[2], mode_phases[3]);
        if (mismatches == 0 && expected_shades.size() == 0)
        begin
            $display("exposure_overlay_pixel_top_test passed");
        end
        else
        begin
            $display("Mismatches: %0d, pixels still expected: %0d.",
                     mismatches, expected_shades.size());
            $display("exposure_overlay_pixel_top_test failed");
        end
        $finish;
    end

endmodule
